FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define AST_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define AST_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/core/srf_pkg.sv
// Shared types and constants of the sample ring FIR filter.
package srf_pkg;

	localparam int DEFAULT_TAPS = 8;
	localparam int NUM_COEFS    = 8;
	localparam int CFG_IDX_W    = 3;
	localparam int SAMPLE_W     = 12;
	localparam int COEF_W       = 16;
	localparam int PROD_W       = COEF_W + SAMPLE_W + 1;
	localparam int ACC_W        = 32;
	localparam int OUT_W        = 16;
	localparam int IN_DATA_W    = 16;

	// Operation codes carried in tuser
	localparam logic OP_STORE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_PUSH
	} state_t;

	// Per-cell load strobes
	typedef struct packed {
		logic smp_ld;
		logic coef_ld;
	} cell_ctrl_t;

	// Strobes from the sequencer to the datapath
	typedef struct packed {
		logic shift;
		logic rotate;
		logic mac_clr;
		logic mac_en;
		logic out_load;
	} seq_ctrl_t;

endpackage

FILE: rtl/core/srf_cell.sv
// One cell of the sample chain: a stored sample and its tap weight.
module srf_cell import srf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctrl_t               ctrl,
	input  logic                     coef_wr,
	input  logic signed [COEF_W-1:0] cfg_data,
	input  logic [SAMPLE_W-1:0]      smp_in,
	input  logic signed [COEF_W-1:0] coef_in,
	output logic [SAMPLE_W-1:0]      smp_q,
	output logic signed [COEF_W-1:0] coef_q
);

	// Take the neighbour's sample on a shift or rotation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_q <= '0;
		end else if (ctrl.smp_ld) begin
			smp_q <= smp_in;
		end
	end

	// Write the weight from the register port, or rotate it with the sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (coef_wr) begin
			coef_q <= cfg_data;
		end else if (ctrl.coef_ld) begin
			coef_q <= coef_in;
		end
	end

endmodule

FILE: rtl/core/srf_mac.sv
// Multiply-accumulate unit with a saturating 32-bit accumulator.
module srf_mac import srf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clr,
	input  logic                     en,
	input  logic signed [COEF_W-1:0] coef,
	input  logic [SAMPLE_W-1:0]      smp,
	output logic signed [OUT_W-1:0]  acc_hi
);

	logic signed [PROD_W-1:0] prod_s1;
	logic                     vld_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W:0]    sum;
	logic signed [ACC_W-1:0]  acc_nxt;

	// Register the product of weight and zero-extended sample
	always_ff @(posedge clk) begin
		prod_s1 <= coef * $signed({1'b0, smp});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= en;
		end
	end

	// Add with one guard bit and clamp to the signed limits
	always_comb begin
		sum = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(prod_s1);
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			acc_nxt = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			acc_nxt = sum[ACC_W-1:0];
		end
	end

	// Clear at the start of a read, accumulate each registered product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clr) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_nxt;
		end
	end

	assign acc_hi = acc_q[ACC_W-1 -: OUT_W];

endmodule

FILE: rtl/core/srf_seq.sv
// Sequencer: takes stores straight from idle, walks the chain once per read.
module srf_seq import srf_pkg::*; #(
	parameter int TAPS = DEFAULT_TAPS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_op,
	input  logic      out_busy,
	output logic      in_ready,
	output seq_ctrl_t ctrl
);

	localparam int CW = (TAPS > 1) ? $clog2(TAPS) : 1;

	state_t        state_q;
	state_t        state_nxt;
	logic [CW-1:0] cnt_q;
	logic          accept;
	logic          cnt_last;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign cnt_last = (cnt_q == CW'(TAPS - 1));

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (in_op == OP_READ)) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cnt_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_PUSH;
			end
			ST_PUSH: begin
				if (!out_busy) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE: begin
				ctrl.shift   = accept && (in_op == OP_STORE);
				ctrl.mac_clr = accept && (in_op == OP_READ);
			end
			ST_RUN: begin
				ctrl.rotate = 1'b1;
				ctrl.mac_en = 1'b1;
			end
			ST_PUSH: begin
				ctrl.out_load = !out_busy;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Count taps during the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_RUN) begin
			cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
		end else begin
			cnt_q <= '0;
		end
	end

endmodule

FILE: rtl/core/sample_ring_fir_filter_core.sv
// A read's result is loaded into the output register after the chain walk, the drain state
// and the push state; stores give none. Throughput: one store per cycle while idle; a read
// holds the input until its result is loaded, later while a stalled result blocks the output
// register; one multiply-accumulate unit takes one tap per cycle from the head of the chain.
// The output register lets a store be taken while a result waits.
// Reset clears every sample and weight to zero at once; no clearing pass.
// Top level of the sample ring FIR filter.
module sample_ring_fir_filter_core import srf_pkg::*; #(
	parameter int TAPS = DEFAULT_TAPS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [IN_DATA_W-1:0] s_axis_tdata,  // [11:0] sample, [15:12] zero
	input  logic [0:0]           s_axis_tuser,  // [0] operation
	// Output stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [OUT_W-1:0]     m_axis_tdata,  // [15:0] filtered
	// Weight register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data
);

	seq_ctrl_t                ctrl;
	cell_ctrl_t               cell_ctrl;
	logic                     out_busy;
	logic [SAMPLE_W-1:0]      smp   [TAPS];
	logic signed [COEF_W-1:0] coef  [TAPS];
	logic signed [OUT_W-1:0]  acc_hi;
	logic                     out_valid_q;
	logic [OUT_W-1:0]         out_data_q;

	assign cfg_ready = 1'b1;
	assign out_busy  = out_valid_q && !m_axis_tready;

	srf_seq #(
		.TAPS(TAPS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser[0]),
		.out_busy (out_busy),
		.in_ready (s_axis_tready),
		.ctrl     (ctrl)
	);

	// Samples move on a store or a rotation; weights only rotate
	assign cell_ctrl.smp_ld  = ctrl.shift || ctrl.rotate;
	assign cell_ctrl.coef_ld = ctrl.rotate;

	// Chain of cells: cell 0 holds the oldest sample, the last cell the newest
	for (genvar i = 0; i < TAPS; i++) begin : g_cell
		localparam int NXT = (i == TAPS - 1) ? 0 : i + 1;
		logic [SAMPLE_W-1:0] smp_in;
		logic                coef_wr;

		if (i == TAPS - 1) begin : g_tail
			assign smp_in = ctrl.shift ? s_axis_tdata[SAMPLE_W-1:0] : smp[NXT];
		end else begin : g_body
			assign smp_in = smp[NXT];
		end

		assign coef_wr = cfg_valid && (cfg_index == CFG_IDX_W'(i));

		srf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl),
			.coef_wr  (coef_wr),
			.cfg_data (cfg_data),
			.smp_in   (smp_in),
			.coef_in  (coef[NXT]),
			.smp_q    (smp[i]),
			.coef_q   (coef[i])
		);
	end

	srf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (ctrl.mac_clr),
		.en     (ctrl.mac_en),
		.coef   (coef[0]),
		.smp    (smp[0]),
		.acc_hi (acc_hi)
	);

	// Output register: hold a result until its transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			out_data_q <= acc_hi;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

FILE: rtl/core/srf_checker.sv
// Port-level checks of the filter core, bound to the top level.
`include "assert_macros.svh"

module srf_checker import srf_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic [0:0]       s_axis_tuser,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	logic rd_acc;
	logic st_acc;

	assign rd_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_READ);
	assign st_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_STORE);

	// Hold a stalled result
	`AST_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	// A store never produces a result
	`AST_NXT(a_store_silent, st_acc && !m_axis_tvalid, !m_axis_tvalid)
	// A read blocks the input while it walks the chain
	`AST_NXT(a_read_busy, rd_acc, !s_axis_tready)
	// A read does not produce its result in the cycle after it is taken
	`AST_NXT(a_read_latency, rd_acc && !m_axis_tvalid, !m_axis_tvalid)

endmodule

bind sample_ring_fir_filter_core srf_checker u_srf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
